[hdl/gns_pkg.sv]
// Package of the Gaussian noise sampler: fixed-point constants, series tables,
// the back-end state type and the structs passed between modules.
// Depends on nothing; every other file but gns_if uses it by scoped names.
package gns_pkg;

	// Fixed-point constants: one in Q2.62, ln 2 and pi/4 in Q0.64.
	localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
	localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;
	localparam logic [63:0] PI4_Q64 = 64'hC90F_DAA2_2168_C235;
	localparam logic [64:0] TWO_64  = 65'h1_0000_0000_0000_0000;

	// Number of Horner terms in the cosine and sine series.
	localparam int unsigned TERMS = 12;

	// Term divisors, indexed by k-1: (2k-1)(2k) for cosine, (2k)(2k+1) for sine.
	localparam logic [9:0] COS_DIV [TERMS] = '{
		10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132,
		10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552
	};
	localparam logic [9:0] SIN_DIV [TERMS] = '{
		10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
		10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
	};

	// Reciprocals floor(2^64 / divisor); the quotient estimate is corrected later.
	localparam logic [63:0] COS_RECIP [TERMS] = '{
		64'(TWO_64 / 65'd2), 64'(TWO_64 / 65'd12), 64'(TWO_64 / 65'd30),
		64'(TWO_64 / 65'd56), 64'(TWO_64 / 65'd90), 64'(TWO_64 / 65'd132),
		64'(TWO_64 / 65'd182), 64'(TWO_64 / 65'd240), 64'(TWO_64 / 65'd306),
		64'(TWO_64 / 65'd380), 64'(TWO_64 / 65'd462), 64'(TWO_64 / 65'd552)
	};
	localparam logic [63:0] SIN_RECIP [TERMS] = '{
		64'(TWO_64 / 65'd6), 64'(TWO_64 / 65'd20), 64'(TWO_64 / 65'd42),
		64'(TWO_64 / 65'd72), 64'(TWO_64 / 65'd110), 64'(TWO_64 / 65'd156),
		64'(TWO_64 / 65'd210), 64'(TWO_64 / 65'd272), 64'(TWO_64 / 65'd342),
		64'(TWO_64 / 65'd420), 64'(TWO_64 / 65'd506), 64'(TWO_64 / 65'd600)
	};

	// Kind of job queued between the front and the back.
	typedef enum logic {
		JOB_BOX,
		JOB_ZERO
	} job_kind_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ_MUL,
		ST_LN_MUL,
		ST_ROOT,
		ST_ANG_MUL,
		ST_A2_MUL,
		ST_TERM_MUL,
		ST_RECIP_MUL,
		ST_QD_MUL,
		ST_CORR,
		ST_SIN_MUL,
		ST_Z_MUL,
		ST_SCALE_MUL,
		ST_DONE
	} core_state_t;

	// Queue status.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Front status: a job is pushed, a first uniform is held.
	typedef struct packed {
		logic push;
		logic held;
	} front_stat_t;

	// Multiplier request and response.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

endpackage

[hdl/gns_if.sv]
// Channel interfaces of the Gaussian noise sampler: random words in, samples
// out, and the sigma write channel. No dependencies.
interface gns_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_word;
	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

interface gns_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface gns_cfg_if;
	logic        valid;
	logic        ready;
	logic [39:0] sigma_fixed;
	modport source (output valid, output sigma_fixed, input ready);
	modport sink (input valid, input sigma_fixed, output ready);
endinterface

[hdl/gaussian_noise_sampler.sv]
// Top level of the Box-Muller Gaussian noise sampler: sigma register, front,
// job queue and back end. Depends on gns_pkg, gns_if, gns_front, gns_fifo, gns_core.
//
//   Channel   Role    Payload              Handshake
//   words     sink    random_word [63:0]   valid/ready
//   samples   source  sample [31:0]        valid/ready
//   cfg       sink    sigma_fixed [39:0]   valid/ready, ready always high
//
// With sigma zero a word becomes a zero sample through the job queue and the
// output register. A pair's cost is set by the shared multiplier (134 64x64
// products) plus the normalize loop, the 60-bit square root and the quotient
// correction of each of the 24 series terms.
// arst_n clears the held uniform, queue, sequencer and output valid; sigma
// resets to 1.0. A stalled sample output blocks the back end, and a full
// queue drops words.ready.
module gaussian_noise_sampler #(
	parameter int unsigned UNIFORM_BITS = 53
) (
	input  logic         clk,
	input  logic         arst_n,
	gns_word_if.sink     words,
	gns_sample_if.source samples,
	gns_cfg_if.sink      cfg
);

	localparam int unsigned JW = 2 * UNIFORM_BITS + 1;

	logic [39:0]          sigma_q;
	logic [JW-1:0]        push_data, head_data;
	logic                 job_pop;
	gns_pkg::fifo_stat_t  fstat;
	gns_pkg::front_stat_t front;

	// Sigma register; the write channel never stalls.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= 40'd65536;
		end else if (cfg.valid) begin
			sigma_q <= cfg.sigma_fixed;
		end
	end

	gns_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.words      (words),
		.sigma_zero (sigma_q == '0),
		.queue_full (fstat.full),
		.job_data   (push_data),
		.stat       (front)
	);

	gns_fifo #(.W(JW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front.push),
		.push_data (push_data),
		.pop       (job_pop),
		.head_data (head_data),
		.stat      (fstat)
	);

	gns_core #(.UNIFORM_BITS(UNIFORM_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.sigma     (sigma_q),
		.job_avail (~fstat.empty),
		.job_data  (head_data),
		.job_pop   (job_pop),
		.samples   (samples)
	);

	// A job is only pushed into a queue with room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		front.push |-> !fstat.full)
		else $error("job pushed into full queue");

	// The back end only pops a queue that holds a job.
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !fstat.empty)
		else $error("job popped from empty queue");

	// A word taken with sigma zero drops any held uniform.
	a_zero_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(words.valid && words.ready && sigma_q == '0) |=> !front.held)
		else $error("uniform still held after zero-sigma word");

endmodule

[hdl/gns_fifo.sv]
// Two-entry job queue between the front and the back of the sampler.
// Depends on gns_pkg for the status struct.
module gns_fifo #(
	parameter int unsigned W = 107
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        push_data,
	input  logic                pop,
	output logic [W-1:0]        head_data,
	output gns_pkg::fifo_stat_t stat
);

	logic [W-1:0] d0_q, d1_q;
	logic         v0_q, v1_q;

	assign head_data  = d0_q;
	assign stat.full  = v0_q & v1_q;
	assign stat.empty = ~v0_q;

	// Valid flags: the head slot always holds the oldest entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (push && pop) begin
			v0_q <= 1'b1;
		end else if (pop) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end else if (push) begin
			if (v0_q) begin
				v1_q <= 1'b1;
			end else begin
				v0_q <= 1'b1;
			end
		end
	end

	// Entry data.
	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (v1_q) begin
				d0_q <= d1_q;
				d1_q <= push_data;
			end else begin
				d0_q <= push_data;
			end
		end else if (pop) begin
			d0_q <= d1_q;
		end else if (push) begin
			if (v0_q) begin
				d1_q <= push_data;
			end else begin
				d0_q <= push_data;
			end
		end
	end

endmodule

[hdl/gns_front.sv]
// Front end of the sampler: accepts random words, classifies them and holds
// the first uniform. Depends on gns_pkg and the word interface.
module gns_front #(
	parameter int unsigned UNIFORM_BITS = 53
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gns_word_if.sink                        words,
	input  logic                            sigma_zero,
	input  logic                            queue_full,
	output logic [2*UNIFORM_BITS:0]         job_data,
	output gns_pkg::front_stat_t            stat
);

	logic [UNIFORM_BITS-1:0] u;
	logic [UNIFORM_BITS-1:0] u1_q;
	logic                    held_q;
	logic                    accept;
	gns_pkg::job_kind_t      kind;

	// Classify the offered word.
	assign u        = words.random_word[63 -: UNIFORM_BITS];
	assign words.ready = ~queue_full;
	assign accept   = words.valid & words.ready;
	assign kind     = sigma_zero ? gns_pkg::JOB_ZERO : gns_pkg::JOB_BOX;
	assign job_data = {kind, u1_q, u};
	assign stat.push = accept & (sigma_zero | ((u != '0) & held_q));
	assign stat.held = held_q;

	// Held-uniform flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (accept) begin
			if (sigma_zero) begin
				held_q <= 1'b0;
			end else if (u != '0) begin
				held_q <= ~held_q;
			end
		end
	end

	// First uniform of a pair.
	always_ff @(posedge clk) begin
		if (accept && !sigma_zero && u != '0 && !held_q) begin
			u1_q <= u;
		end
	end

endmodule

[hdl/gns_mul.sv]
// Shared 64x64 multiplier: four 32x32 partial products summed in turn.
// Depends on gns_pkg for the request and response structs.
module gns_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  gns_pkg::mul_req_t req,
	output gns_pkg::mul_rsp_t rsp,
	output logic              busy
);

	logic [63:0]  a_q, b_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [2:0]   step_q;
	logic         busy_q, done_q;
	logic [31:0]  ai, bj;
	logic [63:0]  pp_d;
	logic [1:0]   prev;
	logic [6:0]   sh;

	// Operand halves for this step and shift for the previous partial product.
	assign ai   = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign bj   = step_q[0] ? b_q[63:32] : b_q[31:0];
	assign pp_d = ai * bj;
	assign prev = 2'(step_q - 3'd1);
	assign sh   = {prev[1] & prev[0], prev[1] ^ prev[0], 5'b0};

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
	assign busy     = busy_q;

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands, partial product and accumulator.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q != 3'd4) begin
				pp_q <= pp_d;
			end
			if (step_q != 3'd0) begin
				acc_q <= acc_q + ({64'b0, pp_q} << sh);
			end
		end
	end

endmodule

[hdl/gns_core.sv]
// Back end of the sampler: sequences log, root, cosine and sine series and
// scaling on the shared multiplier, and holds the output register. Depends on
// gns_pkg, gns_mul and the sample interface.
module gns_core #(
	parameter int unsigned UNIFORM_BITS = 53
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [39:0]             sigma,
	input  logic                    job_avail,
	input  logic [2*UNIFORM_BITS:0] job_data,
	output logic                    job_pop,
	gns_sample_if.source            samples
);

	localparam int unsigned PAD = 64 - UNIFORM_BITS;

	gns_pkg::core_state_t state_q, state_d;
	gns_pkg::mul_req_t    mreq;
	gns_pkg::mul_rsp_t    mrsp;
	logic                 mbusy;

	logic [63:0]  m_q, ph_q, a_q, a2_q, tc_q, ts_q, x_q, q_q, rem_q, sn_q, z_q;
	logic [63:0]  rr_q;
	logic [59:0]  root_q;
	logic [119:0] xs_q;
	logic [55:0]  frac_q;
	logic [5:0]   cnt_q, it_q;
	logic [3:0]   kidx_q;
	logic         sel_q, issued_q;
	logic [31:0]  res_q;
	logic         out_valid_q;
	logic [31:0]  out_sample_q;

	gns_pkg::job_kind_t      kind;
	logic [UNIFORM_BITS-1:0] ju1, ju2;
	logic                    is_mul, out_free, out_write;
	logic [31:0]             out_d;
	logic [63:0]             len, g, r62, mm, dsel, rsel, cm, sm, mag;
	logic [63:0]             rr_n, trial;
	logic                    neg, corr_more;
	logic [40:0]             rnd;
	logic [31:0]             mag32;

	assign kind = gns_pkg::job_kind_t'(job_data[2*UNIFORM_BITS]);
	assign ju1  = job_data[2*UNIFORM_BITS-1 -: UNIFORM_BITS];
	assign ju2  = job_data[UNIFORM_BITS-1:0];

	gns_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp),
		.busy   (mbusy)
	);

	// Arithmetic around the sequencer registers.
	assign len   = (64'({1'b0, cnt_q} + 7'd1) << 56) - {8'b0, frac_q};
	assign r62   = {2'b0, ph_q[61:0]};
	assign g     = ph_q[61] ? ((gns_pkg::ONE_Q62 - r62) << 2) : (r62 << 2);
	assign mm    = mrsp.prod[125:62];
	assign dsel  = {54'b0, sel_q ? gns_pkg::SIN_DIV[kidx_q] : gns_pkg::COS_DIV[kidx_q]};
	assign rsel  = sel_q ? gns_pkg::SIN_RECIP[kidx_q] : gns_pkg::COS_RECIP[kidx_q];
	assign corr_more = rem_q >= dsel;
	assign rr_n  = {rr_q[61:0], xs_q[119:118]};
	assign trial = {2'b0, root_q, 2'b01};
	assign cm    = ph_q[61] ? sn_q : tc_q;
	assign sm    = ph_q[61] ? tc_q : sn_q;
	assign rnd   = {1'b0, mrsp.prod[103:64]} + 41'd128;
	assign mag32 = rnd[39:8];
	assign out_free = ~out_valid_q | samples.ready;

	// Quadrant selects the magnitude and the sign.
	always_comb begin
		case (ph_q[63:62])
			2'd0: begin
				mag = cm;
				neg = 1'b0;
			end
			2'd1: begin
				mag = sm;
				neg = 1'b1;
			end
			2'd2: begin
				mag = cm;
				neg = 1'b1;
			end
			default: begin
				mag = sm;
				neg = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gns_pkg::ST_IDLE: begin
				if (job_avail && kind == gns_pkg::JOB_BOX) state_d = gns_pkg::ST_NORM;
			end
			gns_pkg::ST_NORM: begin
				if (m_q[63] || m_q[62]) state_d = gns_pkg::ST_SQ_MUL;
			end
			gns_pkg::ST_SQ_MUL: begin
				if (mrsp.done && it_q == 6'd55) state_d = gns_pkg::ST_LN_MUL;
			end
			gns_pkg::ST_LN_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_ROOT;
			end
			gns_pkg::ST_ROOT: begin
				if (it_q == 6'd59) state_d = gns_pkg::ST_ANG_MUL;
			end
			gns_pkg::ST_ANG_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_A2_MUL;
			end
			gns_pkg::ST_A2_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_TERM_MUL;
			end
			gns_pkg::ST_TERM_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_RECIP_MUL;
			end
			gns_pkg::ST_RECIP_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_QD_MUL;
			end
			gns_pkg::ST_QD_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_CORR;
			end
			gns_pkg::ST_CORR: begin
				if (!corr_more) begin
					if (sel_q && kidx_q == 4'd0) begin
						state_d = gns_pkg::ST_SIN_MUL;
					end else begin
						state_d = gns_pkg::ST_TERM_MUL;
					end
				end
			end
			gns_pkg::ST_SIN_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_Z_MUL;
			end
			gns_pkg::ST_Z_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_SCALE_MUL;
			end
			gns_pkg::ST_SCALE_MUL: begin
				if (mrsp.done) state_d = gns_pkg::ST_DONE;
			end
			gns_pkg::ST_DONE: begin
				if (out_free) state_d = gns_pkg::ST_IDLE;
			end
			default: state_d = gns_pkg::ST_IDLE;
		endcase
	end

	// Outputs: multiplier operands, queue pop and result write.
	always_comb begin
		is_mul    = 1'b0;
		mreq.a    = m_q;
		mreq.b    = m_q;
		job_pop   = 1'b0;
		out_write = 1'b0;
		out_d     = res_q;
		case (state_q)
			gns_pkg::ST_IDLE: begin
				if (job_avail && kind == gns_pkg::JOB_BOX) begin
					job_pop = 1'b1;
				end else if (job_avail && out_free) begin
					job_pop   = 1'b1;
					out_write = 1'b1;
					out_d     = '0;
				end
			end
			gns_pkg::ST_SQ_MUL: is_mul = 1'b1;
			gns_pkg::ST_LN_MUL: begin
				is_mul = 1'b1;
				mreq.a = len;
				mreq.b = gns_pkg::LN2_Q64;
			end
			gns_pkg::ST_ANG_MUL: begin
				is_mul = 1'b1;
				mreq.a = g;
				mreq.b = gns_pkg::PI4_Q64;
			end
			gns_pkg::ST_A2_MUL: begin
				is_mul = 1'b1;
				mreq.a = a_q;
				mreq.b = a_q;
			end
			gns_pkg::ST_TERM_MUL: begin
				is_mul = 1'b1;
				mreq.a = a2_q;
				mreq.b = sel_q ? ts_q : tc_q;
			end
			gns_pkg::ST_RECIP_MUL: begin
				is_mul = 1'b1;
				mreq.a = x_q;
				mreq.b = rsel;
			end
			gns_pkg::ST_QD_MUL: begin
				is_mul = 1'b1;
				mreq.a = q_q;
				mreq.b = dsel;
			end
			gns_pkg::ST_SIN_MUL: begin
				is_mul = 1'b1;
				mreq.a = a_q;
				mreq.b = ts_q;
			end
			gns_pkg::ST_Z_MUL: begin
				is_mul = 1'b1;
				mreq.a = {4'b0, root_q};
				mreq.b = mag;
			end
			gns_pkg::ST_SCALE_MUL: begin
				is_mul = 1'b1;
				mreq.a = z_q;
				mreq.b = {24'b0, sigma};
			end
			gns_pkg::ST_DONE: out_write = out_free;
			default: ;
		endcase
		mreq.start = is_mul & ~issued_q & ~mbusy;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gns_pkg::ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mreq.start) begin
				issued_q <= 1'b1;
			end else if (mrsp.done) begin
				issued_q <= 1'b0;
			end
			if (out_write) begin
				out_valid_q <= 1'b1;
			end else if (samples.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output data register.
	always_ff @(posedge clk) begin
		if (out_write) begin
			out_sample_q <= out_d;
		end
	end

	assign samples.valid  = out_valid_q;
	assign samples.sample = out_sample_q;

	// Datapath registers, updated by state.
	always_ff @(posedge clk) begin
		case (state_q)
			gns_pkg::ST_IDLE: begin
				m_q   <= 64'(ju1) << PAD;
				ph_q  <= 64'(ju2) << PAD;
				cnt_q <= 6'd1;
			end
			gns_pkg::ST_NORM: begin
				it_q <= '0;
				if (m_q[63]) begin
					m_q   <= m_q >> 1;
					cnt_q <= '0;
				end else if (!m_q[62]) begin
					m_q   <= m_q << 1;
					cnt_q <= cnt_q + 6'd1;
				end
			end
			gns_pkg::ST_SQ_MUL: begin
				if (mrsp.done) begin
					it_q <= it_q + 6'd1;
					if (mm[63]) begin
						m_q    <= mm >> 1;
						frac_q <= {frac_q[54:0], 1'b1};
					end else begin
						m_q    <= mm;
						frac_q <= {frac_q[54:0], 1'b0};
					end
				end
			end
			gns_pkg::ST_LN_MUL: begin
				if (mrsp.done) begin
					xs_q   <= {mrsp.prod[126:63], 56'b0};
					rr_q   <= '0;
					root_q <= '0;
					it_q   <= '0;
				end
			end
			gns_pkg::ST_ROOT: begin
				it_q <= it_q + 6'd1;
				xs_q <= xs_q << 2;
				if (rr_n >= trial) begin
					rr_q   <= rr_n - trial;
					root_q <= {root_q[58:0], 1'b1};
				end else begin
					rr_q   <= rr_n;
					root_q <= {root_q[58:0], 1'b0};
				end
			end
			gns_pkg::ST_ANG_MUL: begin
				if (mrsp.done) a_q <= {1'b0, mrsp.prod[127:65]};
			end
			gns_pkg::ST_A2_MUL: begin
				if (mrsp.done) begin
					a2_q   <= mm;
					tc_q   <= gns_pkg::ONE_Q62;
					ts_q   <= gns_pkg::ONE_Q62;
					kidx_q <= 4'(gns_pkg::TERMS - 1);
					sel_q  <= 1'b0;
				end
			end
			gns_pkg::ST_TERM_MUL: begin
				if (mrsp.done) x_q <= mm;
			end
			gns_pkg::ST_RECIP_MUL: begin
				if (mrsp.done) q_q <= mrsp.prod[127:64];
			end
			gns_pkg::ST_QD_MUL: begin
				if (mrsp.done) rem_q <= x_q - mrsp.prod[63:0];
			end
			gns_pkg::ST_CORR: begin
				// The reciprocal estimate is low by at most one.
				if (corr_more) begin
					q_q   <= q_q + 64'd1;
					rem_q <= rem_q - dsel;
				end else if (sel_q) begin
					ts_q  <= gns_pkg::ONE_Q62 - q_q;
					sel_q <= 1'b0;
					if (kidx_q != 4'd0) kidx_q <= kidx_q - 4'd1;
				end else begin
					tc_q  <= gns_pkg::ONE_Q62 - q_q;
					sel_q <= 1'b1;
				end
			end
			gns_pkg::ST_SIN_MUL: begin
				if (mrsp.done) sn_q <= mm;
			end
			gns_pkg::ST_Z_MUL: begin
				if (mrsp.done) z_q <= mm;
			end
			gns_pkg::ST_SCALE_MUL: begin
				if (mrsp.done) res_q <= neg ? 32'(-mag32) : mag32;
			end
			default: ;
		endcase
	end

endmodule
